// ===== rtl/core/art_pkg.sv =====
// shared types, codes and the per-slot aging function of the aging route table
// no dependencies
package art_pkg;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_BREAK  = 2'd3
  } art_kind_t;

  localparam logic [1:0] ST_ACTIVE  = 2'd0;
  localparam logic [1:0] ST_IDLE    = 2'd1;
  localparam logic [1:0] ST_EXPIRED = 2'd2;
  localparam logic [1:0] ST_BROKEN  = 2'd3;

  localparam logic [1:0] REG_ACTIVE_TIMEOUT  = 2'd0;
  localparam logic [1:0] REG_MAX_IDLE_TIME   = 2'd1;
  localparam logic [1:0] REG_SEQNUM_LIFETIME = 2'd2;

  localparam int RESULT_LIMIT = 16;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_WALK,
    FSM_FINISH
  } art_fsm_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now_ms;
    logic [63:0] dest_addr;
    logic [7:0]  metric_kind;
    logic [63:0] hop_addr;
    logic [15:0] in_seqnum;
    logic [7:0]  in_metric;
    logic [1:0]  in_state;
    logic [31:0] in_expiry;
    logic [31:0] in_last_used;
  } art_in_t;

  typedef struct packed {
    logic        found;
    logic [63:0] out_addr;
    logic [63:0] out_next_hop;
    logic [15:0] out_seqnum;
    logic [7:0]  out_metric;
    logic [1:0]  out_state;
    logic [31:0] out_expiry;
    logic [31:0] out_last_used;
    logic        last;
  } art_out_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] dest;
    logic [7:0]  metric_kind;
    logic [63:0] next_hop;
    logic [15:0] seqnum;
    logic [7:0]  metric;
    logic [1:0]  route_state;
    logic [31:0] expiry;
    logic [31:0] last_used;
  } art_entry_t;

  typedef struct packed {
    logic [31:0] active_timeout;
    logic [31:0] max_idle_time;
    logic [31:0] seqnum_lifetime;
  } art_cfg_t;

  typedef struct packed {
    logic key_hit;
    logic hop_hit;
  } art_hit_t;

  function automatic logic [31:0] sat_sub(input logic [31:0] a, input logic [31:0] b);
    return (a > b) ? (a - b) : 32'd0;
  endfunction

  function automatic art_entry_t age_entry(input art_entry_t e, input logic [31:0] now,
                                           input art_cfg_t cfg);
    art_entry_t r;
    r = e;
    if (e.valid && e.expiry != 32'd0 && now >= cfg.active_timeout) begin
      if (e.route_state == ST_ACTIVE && sat_sub(now, cfg.active_timeout) > e.last_used) begin
        r.route_state = ST_IDLE;
        r.last_used   = now;
      end
      if (now >= e.expiry) begin
        if (e.route_state == ST_IDLE &&
            (sat_sub(now, cfg.max_idle_time) > e.last_used || e.expiry <= now)) begin
          r.route_state = ST_EXPIRED;
          r.last_used   = now;
        end
        if (sat_sub(now, e.last_used) >= cfg.seqnum_lifetime) begin
          r = '0;
        end
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/art_cell.sv =====
// one table slot of the route ring: shifts from its neighbor or takes a direct write
// depends on art_pkg
module art_cell #(
  parameter int IDXW = 4,
  parameter int IDX  = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift_en,
  input  art_pkg::art_entry_t shift_d,
  input  logic                wr_en,
  input  logic [IDXW-1:0]     wr_idx,
  input  art_pkg::art_entry_t wr_d,
  output art_pkg::art_entry_t q
);
  import art_pkg::*;

  art_entry_t slot_r;
  art_entry_t slot_nxt;

  always_comb begin
    slot_nxt = slot_r;
    if (wr_en && wr_idx == IDXW'(IDX)) begin
      slot_nxt = wr_d;
    end else if (shift_en) begin
      slot_nxt = shift_d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  assign q = slot_r;
endmodule

// ===== rtl/core/art_age.sv =====
// head unit of the ring: ages the slot at the head unless bypassed and checks it against the request keys
// depends on art_pkg
module art_age #(
  parameter int ADDR_BITS = 64
) (
  input  art_pkg::art_entry_t head,
  input  logic                bypass,
  input  art_pkg::art_in_t    req,
  input  art_pkg::art_cfg_t   cfg,
  output art_pkg::art_entry_t aged,
  output art_pkg::art_hit_t   hit
);
  import art_pkg::*;

  localparam logic [63:0] ADDR_MASK = {64{1'b1}} >> (64 - ADDR_BITS);

  always_comb begin
    aged = bypass ? head : age_entry(head, req.now_ms, cfg);
    hit.key_hit = aged.valid && aged.dest == (req.dest_addr & ADDR_MASK) &&
                  aged.metric_kind == req.metric_kind;
    hit.hop_hit = aged.valid && aged.next_hop == (req.hop_addr & ADDR_MASK);
  end
endmodule

// ===== rtl/core/aging_route_table_core.sv =====
// top level of the aging route table: ring of slot cells, head unit and walk sequencer
// depends on art_pkg, art_cell, art_age
//
//  channel | ports                                   | direction
//  request | in_valid, in_ready, in_data             | in
//  result  | out_valid, out_ready, out_data          | out
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// each request rotates the whole ring once, then the finish state issues the result,
// and the idle state takes the next request; a new request waits until the last is done
// a break result waits in a hold register; the ring stalls while a new report finds the
// hold and the output register both full
// reset empties every slot at once; config writes are taken in any cycle
module aging_route_table_core #(
  parameter int TABLE_ENTRIES   = 16,
  parameter int MAX_UNREACHABLE = 16,
  parameter int ADDR_BITS       = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  art_pkg::art_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output art_pkg::art_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import art_pkg::*;

  localparam int IDXW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CAP  = (MAX_UNREACHABLE < RESULT_LIMIT) ? MAX_UNREACHABLE : RESULT_LIMIT;
  localparam int RW   = $clog2(CAP + 1);
  localparam logic [63:0] ADDR_MASK = {64{1'b1}} >> (64 - ADDR_BITS);

  art_fsm_t   fsm_r, fsm_nxt;
  art_cfg_t   cfg_r, cfg_nxt;
  art_in_t    req_r, req_nxt;
  logic [IDXW-1:0] cnt_r, cnt_nxt;
  logic       stop_r, stop_nxt;
  logic       free_v_r, free_v_nxt;
  logic [IDXW-1:0] free_idx_r, free_idx_nxt;
  logic       hold_v_r, hold_v_nxt;
  art_out_t   hold_r, hold_nxt;
  logic [RW-1:0] rep_r, rep_nxt;
  logic       out_v_r, out_v_nxt;
  art_out_t   out_r, out_nxt;

  art_entry_t cell_q [TABLE_ENTRIES];
  art_entry_t tail_d;
  art_entry_t aged;
  art_entry_t new_entry;
  art_hit_t   hit;
  logic       shift_en;
  logic       wr_en;
  logic       out_free;
  logic       report;

  art_age #(.ADDR_BITS(ADDR_BITS)) u_age (
    .head   (cell_q[0]),
    .bypass (stop_r),
    .req    (req_r),
    .cfg    (cfg_r),
    .aged   (aged),
    .hit    (hit)
  );

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    art_entry_t sd;
    if (k == TABLE_ENTRIES - 1) begin : g_tail
      assign sd = tail_d;
    end else begin : g_mid
      assign sd = cell_q[k+1];
    end
    art_cell #(.IDXW(IDXW), .IDX(k)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .shift_d  (sd),
      .wr_en    (wr_en),
      .wr_idx   (free_idx_r),
      .wr_d     (new_entry),
      .q        (cell_q[k])
    );
  end

  always_comb begin
    new_entry.valid       = 1'b1;
    new_entry.dest        = req_r.dest_addr & ADDR_MASK;
    new_entry.metric_kind = req_r.metric_kind;
    new_entry.next_hop    = req_r.hop_addr & ADDR_MASK;
    new_entry.seqnum      = req_r.in_seqnum;
    new_entry.metric      = req_r.in_metric;
    new_entry.route_state = req_r.in_state;
    new_entry.expiry      = req_r.in_expiry;
    new_entry.last_used   = req_r.in_last_used;
  end

  assign out_free = !out_v_r || out_ready;

  always_comb begin
    fsm_nxt      = fsm_r;
    cfg_nxt      = cfg_r;
    req_nxt      = req_r;
    cnt_nxt      = cnt_r;
    stop_nxt     = stop_r;
    free_v_nxt   = free_v_r;
    free_idx_nxt = free_idx_r;
    hold_v_nxt   = hold_v_r;
    hold_nxt     = hold_r;
    rep_nxt      = rep_r;
    out_v_nxt    = out_v_r && !out_ready;
    out_nxt      = out_r;
    tail_d       = aged;
    shift_en     = 1'b0;
    wr_en        = 1'b0;
    report       = 1'b0;

    if (cfg_valid) begin
      unique case (cfg_index)
        REG_ACTIVE_TIMEOUT:  cfg_nxt.active_timeout  = cfg_data;
        REG_MAX_IDLE_TIME:   cfg_nxt.max_idle_time   = cfg_data;
        REG_SEQNUM_LIFETIME: cfg_nxt.seqnum_lifetime = cfg_data;
        default: ;
      endcase
    end

    unique case (fsm_r)
      FSM_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_data;
          cnt_nxt    = '0;
          stop_nxt   = 1'b0;
          free_v_nxt = 1'b0;
          hold_v_nxt = 1'b0;
          rep_nxt    = '0;
          fsm_nxt    = FSM_WALK;
        end
      end
      FSM_WALK: begin
        shift_en = 1'b1;
        if (req_r.kind == KIND_BREAK) begin
          if (hit.hop_hit) begin
            tail_d.route_state = ST_BROKEN;
            report = (aged.route_state == ST_ACTIVE) && (rep_r < RW'(CAP));
          end
          if (report) begin
            if (hold_v_r && !out_free) begin
              shift_en = 1'b0;
            end else begin
              if (hold_v_r) begin
                out_nxt   = hold_r;
                out_v_nxt = 1'b1;
              end
              hold_nxt          = '0;
              hold_nxt.found    = 1'b1;
              hold_nxt.out_addr = aged.dest;
              hold_nxt.out_seqnum = aged.seqnum;
              hold_v_nxt        = 1'b1;
              rep_nxt           = rep_r + RW'(1);
            end
          end
        end else if (!stop_r) begin
          if (hit.key_hit) begin
            stop_nxt = 1'b1;
            if (req_r.kind != KIND_ADD) begin
              hold_nxt.found         = 1'b1;
              hold_nxt.out_addr      = aged.dest;
              hold_nxt.out_next_hop  = aged.next_hop;
              hold_nxt.out_seqnum    = aged.seqnum;
              hold_nxt.out_metric    = aged.metric;
              hold_nxt.out_state     = aged.route_state;
              hold_nxt.out_expiry    = aged.expiry;
              hold_nxt.out_last_used = aged.last_used;
              hold_nxt.last          = 1'b0;
              hold_v_nxt             = 1'b1;
            end
            if (req_r.kind == KIND_DELETE) begin
              tail_d = '0;
            end
          end else if (req_r.kind == KIND_ADD && !aged.valid && !free_v_r) begin
            free_v_nxt   = 1'b1;
            free_idx_nxt = cnt_r;
          end
        end
        if (shift_en) begin
          cnt_nxt = cnt_r + IDXW'(1);
          if (cnt_r == IDXW'(TABLE_ENTRIES - 1)) begin
            fsm_nxt = FSM_FINISH;
          end
        end
      end
      FSM_FINISH: begin
        if (out_free) begin
          out_v_nxt = 1'b1;
          out_nxt   = '0;
          if (req_r.kind == KIND_ADD) begin
            if (!stop_r && free_v_r) begin
              wr_en                 = 1'b1;
              out_nxt.found         = 1'b1;
              out_nxt.out_addr      = new_entry.dest;
              out_nxt.out_next_hop  = new_entry.next_hop;
              out_nxt.out_seqnum    = new_entry.seqnum;
              out_nxt.out_metric    = new_entry.metric;
              out_nxt.out_state     = new_entry.route_state;
              out_nxt.out_expiry    = new_entry.expiry;
              out_nxt.out_last_used = new_entry.last_used;
            end
          end else if (hold_v_r) begin
            out_nxt = hold_r;
          end
          out_nxt.last = 1'b1;
          fsm_nxt      = FSM_IDLE;
        end
      end
      default: fsm_nxt = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r    <= FSM_IDLE;
      cfg_r.active_timeout  <= 32'd5000;
      cfg_r.max_idle_time   <= 32'd200000;
      cfg_r.seqnum_lifetime <= 32'd300000;
      cnt_r    <= '0;
      stop_r   <= 1'b0;
      free_v_r <= 1'b0;
      hold_v_r <= 1'b0;
      rep_r    <= '0;
      out_v_r  <= 1'b0;
    end else begin
      fsm_r    <= fsm_nxt;
      cfg_r    <= cfg_nxt;
      cnt_r    <= cnt_nxt;
      stop_r   <= stop_nxt;
      free_v_r <= free_v_nxt;
      hold_v_r <= hold_v_nxt;
      rep_r    <= rep_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    free_idx_r <= free_idx_nxt;
    hold_r     <= hold_nxt;
    out_r      <= out_nxt;
  end

  assign in_ready  = (fsm_r == FSM_IDLE);
  assign out_valid = out_v_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;
endmodule
